FILE: rtl/arpr_pkg.sv
// Shared types and constants for the ARP request responder.
// No dependencies; used by arpr_ctrl, arpr_dp and arp_request_responder_top.
package arpr_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int MAC_BYTES   = 6;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] OPER_REQUEST  = 16'h0001;
    localparam logic [15:0] OPER_REPLY    = 16'h0002;

    localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(42);

    // Byte offsets in the frame
    localparam logic [CNT_W-1:0] OFF_SRC   = CNT_W'(MAC_BYTES);
    localparam logic [CNT_W-1:0] OFF_ETYPE = CNT_W'(12);
    localparam logic [CNT_W-1:0] OFF_OPER  = CNT_W'(20);
    localparam logic [CNT_W-1:0] OFF_SHA   = CNT_W'(22);
    localparam logic [CNT_W-1:0] OFF_SPA   = CNT_W'(28);
    localparam logic [CNT_W-1:0] OFF_THA   = CNT_W'(32);
    localparam logic [CNT_W-1:0] OFF_TPA   = CNT_W'(38);
    localparam logic [CNT_W-1:0] OFF_END   = CNT_W'(42);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = CFG_IDX_W'(1);

    typedef struct packed {
        logic store;
        logic clear_frame;
        logic rd_en;
        logic idx_clear;
        logic load_reply;
        logic load_drop;
    } dp_cmd_t;

    typedef struct packed {
        logic match;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/arpr_ctrl.sv
// Controller state machine of the ARP request responder.
// Depends on arpr_pkg; drives arpr_dp through dp_cmd_t and reads dp_status_t.
module arpr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  arpr_pkg::dp_status_t status,
    output arpr_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_RECV  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_REQ   = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DROP  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_RECV:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.match)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_REQ;
                end
                else
                begin
                    state_next = ST_DROP;
                end
            end
            ST_REQ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_reply = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.clear_frame = 1'b1;
                        state_next      = ST_RECV;
                    end
                    else
                    begin
                        state_next = ST_REQ;
                    end
                end
            end
            ST_DROP:
            begin
                if (status.out_free)
                begin
                    cmd.load_drop   = 1'b1;
                    cmd.clear_frame = 1'b1;
                    state_next      = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // A buffer read always precedes loading a reply word
    a_load_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_reply |-> $past(state_reg) == ST_REQ || $past(state_reg) == ST_LOAD)
        else $error("reply word loaded without a buffer read");

    // Input is held off for the whole check and reply
    a_no_input_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REQ || state_reg == ST_LOAD || state_reg == ST_CHECK) |-> !cmd.store)
        else $error("byte stored outside receive");

endmodule

FILE: rtl/arpr_dp.sv
// Datapath of the ARP request responder: frame buffer, header capture, config
// registers, reply byte rewrite and output register. Depends on arpr_pkg.
module arpr_dp
#(
    parameter int FRAME_BYTES = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  arpr_pkg::dp_cmd_t                   cmd,
    output arpr_pkg::dp_status_t                status,
    input  logic [7:0]                          in_byte,
    input  logic                                cfg_we,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arpr_pkg::MAC_W-1:0]          cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    output logic                                out_drop
);

    logic [7:0] mem [arpr_pkg::STORE_DEPTH];
    logic [7:0] rdata_reg;

    logic [arpr_pkg::CNT_W-1:0]  byte_count_reg;
    logic                        overflow_reg;
    logic [arpr_pkg::ADDR_W-1:0] idx_reg;
    logic [15:0]                 etype_reg;
    logic [15:0]                 oper_reg;
    logic [arpr_pkg::IP_W-1:0]   tpa_reg;
    logic [arpr_pkg::IP_W-1:0]   own_ip_reg;
    logic [arpr_pkg::MAC_W-1:0]  own_mac_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic                        out_last_reg;
    logic                        out_drop_reg;

    logic                        can_store;
    logic [arpr_pkg::CNT_W-1:0]  idx_ext;
    logic [arpr_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  reply_byte;
    logic [2:0]                  mac_k;
    logic [1:0]                  ip_k;

    assign can_store = byte_count_reg < arpr_pkg::CNT_W'(FRAME_BYTES);
    assign idx_ext   = {1'b0, idx_reg};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == arpr_pkg::REG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[arpr_pkg::IP_W-1:0];
            end
            else if (cfg_index == arpr_pkg::REG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data;
            end
        end
    end

    // Frame buffer
    always_ff @(posedge clk)
    begin
        if (cmd.store && can_store)
        begin
            mem[byte_count_reg[arpr_pkg::ADDR_W-1:0]] <= in_byte;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cmd.clear_frame)
            begin
                byte_count_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            else if (cmd.store)
            begin
                if (can_store)
                begin
                    byte_count_reg <= byte_count_reg + arpr_pkg::CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.load_reply)
            begin
                idx_reg <= idx_reg + arpr_pkg::ADDR_W'(1);
            end
        end
    end

    // Header fields captured as they stream in
    always_ff @(posedge clk)
    begin
        if (cmd.store && can_store)
        begin
            if (byte_count_reg == arpr_pkg::OFF_ETYPE)
            begin
                etype_reg[15:8] <= in_byte;
            end
            if (byte_count_reg == arpr_pkg::OFF_ETYPE + arpr_pkg::CNT_W'(1))
            begin
                etype_reg[7:0] <= in_byte;
            end
            if (byte_count_reg == arpr_pkg::OFF_OPER)
            begin
                oper_reg[15:8] <= in_byte;
            end
            if (byte_count_reg == arpr_pkg::OFF_OPER + arpr_pkg::CNT_W'(1))
            begin
                oper_reg[7:0] <= in_byte;
            end
            if (byte_count_reg >= arpr_pkg::OFF_TPA && byte_count_reg < arpr_pkg::OFF_END)
            begin
                tpa_reg <= {tpa_reg[arpr_pkg::IP_W-9:0], in_byte};
            end
        end
    end

    assign status.match    = !overflow_reg
                          && byte_count_reg >= arpr_pkg::MIN_FRAME
                          && etype_reg == arpr_pkg::ETHERTYPE_ARP
                          && oper_reg == arpr_pkg::OPER_REQUEST
                          && tpa_reg == own_ip_reg;
    assign status.idx_last = (idx_ext + arpr_pkg::CNT_W'(1)) == byte_count_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // Buffer address for reply byte idx
    always_comb
    begin
        if (idx_ext < arpr_pkg::OFF_SRC)
        begin
            rd_addr = idx_reg + arpr_pkg::ADDR_W'(arpr_pkg::MAC_BYTES);
        end
        else if (idx_ext >= arpr_pkg::OFF_THA && idx_ext < arpr_pkg::OFF_END)
        begin
            rd_addr = idx_reg - arpr_pkg::ADDR_W'(arpr_pkg::OFF_THA - arpr_pkg::OFF_SHA);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    always_comb
    begin
        mac_k = 3'(idx_ext - arpr_pkg::OFF_SRC);
        ip_k  = 2'(idx_ext - arpr_pkg::OFF_SPA);
        if (idx_ext >= arpr_pkg::OFF_SHA && idx_ext < arpr_pkg::OFF_SPA)
        begin
            mac_k = 3'(idx_ext - arpr_pkg::OFF_SHA);
        end
        if (idx_ext >= arpr_pkg::OFF_SRC && idx_ext < arpr_pkg::OFF_ETYPE)
        begin
            reply_byte = 8'(own_mac_reg >> {3'd5 - mac_k, 3'b000});
        end
        else if (idx_ext == arpr_pkg::OFF_OPER)
        begin
            reply_byte = arpr_pkg::OPER_REPLY[15:8];
        end
        else if (idx_ext == arpr_pkg::OFF_OPER + arpr_pkg::CNT_W'(1))
        begin
            reply_byte = arpr_pkg::OPER_REPLY[7:0];
        end
        else if (idx_ext >= arpr_pkg::OFF_SHA && idx_ext < arpr_pkg::OFF_SPA)
        begin
            reply_byte = 8'(own_mac_reg >> {3'd5 - mac_k, 3'b000});
        end
        else if (idx_ext >= arpr_pkg::OFF_SPA && idx_ext < arpr_pkg::OFF_THA)
        begin
            reply_byte = 8'(own_ip_reg >> {2'd3 - ip_k, 3'b000});
        end
        else
        begin
            reply_byte = rdata_reg;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_reply || cmd.load_drop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_reply)
        begin
            out_byte_reg <= reply_byte;
            out_last_reg <= status.idx_last;
            out_drop_reg <= 1'b0;
        end
        else if (cmd.load_drop)
        begin
            out_byte_reg <= 8'h00;
            out_last_reg <= 1'b1;
            out_drop_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_drop  = out_drop_reg;

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_reply || cmd.load_drop) |-> status.out_free)
        else $error("output word overwritten before taken");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= arpr_pkg::CNT_W'(FRAME_BYTES))
        else $error("byte count beyond buffer limit");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_reply && cmd.load_drop))
        else $error("reply and drop loaded together");

endmodule

FILE: rtl/arp_request_responder_top.sv
// Top level of the ARP request responder: streaming ports and config port.
// Depends on arpr_pkg, arpr_ctrl and arpr_dp.
// Bytes are taken one per cycle while receiving; then the frame is checked and a drop
// word is loaded, or each reply word is read, then loaded once the output is free.
// Input is held off from the last byte until the final result is loaded.
// Reset (rst_n low, asynchronous) clears control state and config; buffer is not cleared.
module arp_request_responder_top
#(
    parameter int FRAME_BYTES = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tlast,
    output logic [0:0]                     m_axis_tuser,   // [0] out_drop
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arpr_pkg::MAC_W-1:0]     cfg_data
);

    arpr_pkg::dp_cmd_t    cmd;
    arpr_pkg::dp_status_t status;
    logic                 out_drop;

    assign cfg_ready       = 1'b1;
    assign m_axis_tuser[0] = out_drop;

    arpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arpr_dp
    #(
        .FRAME_BYTES (FRAME_BYTES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_axis_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_drop  (out_drop)
    );

endmodule
